>>> rtl/core/fcce_pkg.sv
// fcce_pkg: types, codes and constants shared by the cluster chain engine
// and its port checker. No dependencies.
package fcce_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 4096;

	localparam int CLUSTER_W = 12;
	localparam int LINK_W    = 28;
	localparam int SKIP_W    = 12;
	localparam int CUR_W     = 13;   // data clusters stay below 4097

	localparam logic [CLUSTER_W-1:0] CLUSTER_COUNT_RST = 12'd4094;

	localparam logic [LINK_W-1:0] END_MIN    = 28'hFFFFFF8;
	localparam logic [LINK_W-1:0] END_MARK   = 28'hFFFFFFF;
	localparam logic [LINK_W-1:0] FIRST_DATA = 28'd2;

	localparam logic [2:0] CMD_READ   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_FOLLOW = 3'd2;
	localparam logic [2:0] CMD_ALLOC  = 3'd3;
	localparam logic [2:0] CMD_EXTEND = 3'd4;
	localparam logic [2:0] CMD_FREE   = 3'd5;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_END   = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CHECK,
		S_LINK
	} fcce_state_t;

	typedef struct packed {
		logic [2:0]           command;
		logic [CLUSTER_W-1:0] cluster;
		logic [LINK_W-1:0]    link_value;
		logic [SKIP_W-1:0]    skip_count;
	} fcce_item_t;

	typedef struct packed {
		logic [LINK_W-1:0] result_cluster;
		logic [1:0]        status;
	} fcce_result_t;

endpackage

>>> rtl/core/fat_cluster_chain_engine.sv
// fat_cluster_chain_engine: FAT32 allocation table with chain walk, allocate,
// extend and free commands over one table memory. Depends on fcce_pkg.
//
//  channel   signals                         handshake
//  --------  ------------------------------  ---------------------------------
//  command   start, busy, item               taken when start && !busy
//  result    done, result                    one-cycle strobe, cannot be held
//  config    psel penable pwrite paddr ...   APB, pready tied high
//
// Read takes one table access, write and invalid starts finish from idle,
// follow and free take one access per link, allocate one per entry scanned
// (plus a final S_READ when full), extend as allocate plus the S_LINK write.
// Every table access is one trip through the single registered read port, then S_CHECK.
// After reset a clearing pass (S_CLEAR) writes every entry to zero with busy
// high. The receiver cannot stall; done pulses with busy low.
module fat_cluster_chain_engine
	import fcce_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  fcce_item_t   item,
	output logic         done,
	output fcce_result_t result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam logic [LINK_W-1:0] TE_L = LINK_W'(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

	logic [LINK_W-1:0] fat_mem [TABLE_ENTRIES];

	fcce_state_t          state_q, state_d;
	logic [AW-1:0]        clr_q;
	logic [CLUSTER_W-1:0] cc_q;
	logic                 done_q;
	fcce_result_t         result_q;
	logic [2:0]           cmd_q;
	logic [CLUSTER_W-1:0] cl_q;
	logic [CUR_W-1:0]     cur_q, cur_d;
	logic [SKIP_W-1:0]    cnt_q, cnt_d;
	logic [LINK_W-1:0]    rd_q;

	logic              accept;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [LINK_W-1:0] mem_wd;
	logic [AW-1:0]     cur_addr;
	logic [LINK_W-1:0] cur28, cl28, clq28;
	logic [LINK_W-1:0] lim_sum, lim;
	logic              fin, to_read, to_check, to_link, clr_done;
	logic [LINK_W-1:0] fin_res;
	logic [1:0]        fin_st;
	logic              scan_cmd;

	function automatic logic is_data(input logic [LINK_W-1:0] x,
			input logic [LINK_W-1:0] l);
		return (x >= FIRST_DATA) && (x < l);
	endfunction

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign cur28    = LINK_W'(cur_q);
	assign cl28     = LINK_W'(item.cluster);
	assign clq28    = LINK_W'(cl_q);
	assign cur_addr = cur28[AW-1:0];
	assign scan_cmd = (cmd_q == CMD_ALLOC) || (cmd_q == CMD_EXTEND);

	// upper end of the data range: min(cluster_count + 2, table size)
	assign lim_sum = LINK_W'(cc_q) + FIRST_DATA;
	assign lim     = (lim_sum > TE_L) ? TE_L : lim_sum;

	// datapath and memory control
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = cur_addr;
		mem_wd   = '0;
		cur_d    = cur_q;
		cnt_d    = cnt_q;
		fin      = 1'b0;
		fin_res  = '0;
		fin_st   = STAT_OK;
		to_read  = 1'b0;
		to_check = 1'b0;
		to_link  = 1'b0;
		clr_done = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				clr_done = (clr_q == LAST_ADDR);
			end
			S_IDLE: begin
				if (accept) begin
					unique case (item.command)
						CMD_READ: begin
							if (cl28 < TE_L) begin
								cur_d = CUR_W'(item.cluster);
								to_read = 1'b1;
							end else begin
								fin = 1'b1;
								fin_st = STAT_RANGE;
							end
						end
						CMD_WRITE: begin
							fin = 1'b1;
							if (cl28 < TE_L) begin
								mem_we = 1'b1;
								mem_wa = cl28[AW-1:0];
								mem_wd = item.link_value;
							end else begin
								fin_st = STAT_RANGE;
							end
						end
						CMD_FOLLOW: begin
							if (!is_data(cl28, lim)) begin
								fin = 1'b1;
								fin_st = STAT_RANGE;
							end else if (item.skip_count == '0) begin
								fin = 1'b1;
								fin_res = cl28;
							end else begin
								cur_d = CUR_W'(item.cluster);
								cnt_d = item.skip_count;
								to_read = 1'b1;
							end
						end
						CMD_ALLOC: begin
							cur_d = FIRST_DATA[CUR_W-1:0];
							to_read = 1'b1;
						end
						CMD_EXTEND: begin
							if (!is_data(cl28, lim)) begin
								fin = 1'b1;
								fin_st = STAT_RANGE;
							end else begin
								cur_d = FIRST_DATA[CUR_W-1:0];
								to_read = 1'b1;
							end
						end
						CMD_FREE: begin
							if (!is_data(cl28, lim)) begin
								fin = 1'b1;
								fin_st = STAT_RANGE;
							end else begin
								cur_d = CUR_W'(item.cluster);
								to_read = 1'b1;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_READ: begin
				// free scan ran off the data range
				if (scan_cmd && (cur28 >= lim)) begin
					fin = 1'b1;
					fin_st = STAT_FULL;
				end else begin
					to_check = 1'b1;
				end
			end
			S_CHECK: begin
				unique case (cmd_q)
					CMD_READ: begin
						fin = 1'b1;
						fin_res = rd_q;
					end
					CMD_FOLLOW: begin
						if (rd_q >= END_MIN) begin
							fin = 1'b1;
							fin_st = STAT_END;
						end else if (!is_data(rd_q, lim)) begin
							fin = 1'b1;
							fin_st = STAT_RANGE;
						end else begin
							cur_d = rd_q[CUR_W-1:0];
							cnt_d = cnt_q - SKIP_W'(1);
							if (cnt_q == SKIP_W'(1)) begin
								fin = 1'b1;
								fin_res = rd_q;
							end else begin
								to_read = 1'b1;
							end
						end
					end
					CMD_ALLOC, CMD_EXTEND: begin
						if (rd_q == '0) begin
							mem_we = 1'b1;
							mem_wd = END_MARK;
							if (cmd_q == CMD_ALLOC) begin
								fin = 1'b1;
								fin_res = cur28;
							end else begin
								to_link = 1'b1;
							end
						end else begin
							cur_d = cur_q + CUR_W'(1);
							to_read = 1'b1;
						end
					end
					CMD_FREE: begin
						mem_we = 1'b1;
						if (rd_q >= END_MIN) begin
							fin = 1'b1;
						end else if (!is_data(rd_q, lim)) begin
							fin = 1'b1;
							fin_st = STAT_RANGE;
						end else begin
							cur_d = rd_q[CUR_W-1:0];
							to_read = 1'b1;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			S_LINK: begin
				// hook the new cluster onto the old chain tail
				mem_we = 1'b1;
				mem_wa = clq28[AW-1:0];
				mem_wd = cur28;
				fin = 1'b1;
				fin_res = cur28;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		priority if (clr_done) state_d = S_IDLE;
		else if (fin)          state_d = S_IDLE;
		else if (to_read)      state_d = S_READ;
		else if (to_check)     state_d = S_CHECK;
		else if (to_link)      state_d = S_LINK;
		else                   state_d = state_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			cc_q    <= CLUSTER_COUNT_RST;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			if (psel && penable && pwrite && !paddr[2]) cc_q <= pwdata[CLUSTER_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		cnt_q <= cnt_d;
		if (accept) begin
			cmd_q <= item.command;
			cl_q  <= item.cluster;
		end
		if (fin) begin
			result_q.result_cluster <= fin_res;
			result_q.status         <= fin_st;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) fat_mem[mem_wa] <= mem_wd;
		rd_q <= fat_mem[cur_addr];
	end

	assign done   = done_q;
	assign result = result_q;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(cc_q);

endmodule

>>> rtl/core/fcce_checker.sv
// fcce_port_asserts: port-level assertions for fat_cluster_chain_engine,
// attached by the bind at the end of this file. Depends on fcce_pkg.
module fcce_port_asserts
	import fcce_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input logic         busy,
	input logic         done,
	input fcce_result_t result,
	input logic         pready
);

	// a result is only shown once the engine is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted item either answers at once or keeps the engine busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item dropped");

	// error and full answers carry no cluster
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == STAT_END || result.status == STAT_FULL ||
			result.status == STAT_RANGE)) |-> (result.result_cluster == '0))
		else $error("nonzero cluster with error status");

	// a done strobe lasts one cycle unless a new item was taken
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !start) |=> !done)
		else $error("done repeated without a new item");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind fat_cluster_chain_engine fcce_port_asserts u_fcce_port_asserts (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result),
	.pready (pready)
);
